FILE: design/im2col_pkg.sv
package im2col_pkg;

    localparam int MAX_IMAGE    = 32;
    localparam int MAX_CHANNELS = 16;
    localparam int MAX_KERNEL   = 8;
    localparam int MAX_STRIDE   = 8;
    localparam int WORD_BITS    = 32;

    localparam int STORE_DEPTH = MAX_IMAGE * MAX_IMAGE * MAX_CHANNELS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int SIZE_W   = 6;
    localparam int CHAN_W   = 5;
    localparam int KSIZE_W  = 4;
    localparam int STRIDE_W = 4;

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int KW_W  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int POS_W = (MAX_IMAGE > 1) ? $clog2(MAX_IMAGE) : 1;

    // channel * size + row + window row
    localparam int ROW_W  = $clog2(MAX_CHANNELS * MAX_IMAGE + MAX_IMAGE + MAX_KERNEL);
    localparam int COL_W  = POS_W + 1;
    localparam int PROD_W = ROW_W + SIZE_W;

    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    localparam int OPCODE_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FETCH = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_STRIDE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE   = 3'd4;

    typedef struct packed {
        logic [SIZE_W-1:0]   size;
        logic [CHAN_W-1:0]   chans;
        logic [KSIZE_W-1:0]  ksize;
        logic [STRIDE_W-1:0] stride;
        logic                row_layout;
    } geom_t;

    typedef struct packed {
        logic              load;
        logic              fetch;
        logic              no_elem;
        logic              last;
        logic [ADDR_W-1:0] ld_addr;
        logic [CH_W-1:0]   ch;
        logic [KW_W-1:0]   wr;
        logic [KW_W-1:0]   wc;
        logic [POS_W-1:0]  pr;
        logic [POS_W-1:0]  pc;
    } req_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 last;
        logic                 no_elem;
    } result_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > SIZE_W'(MAX_IMAGE))
            r = SIZE_W'(MAX_IMAGE);
        return r;
    endfunction

    function automatic logic [CHAN_W-1:0] clamp_chans(input logic [CHAN_W-1:0] v);
        logic [CHAN_W-1:0] r;
        r = v;
        if (v == '0)
            r = CHAN_W'(1);
        else if (v > CHAN_W'(MAX_CHANNELS))
            r = CHAN_W'(MAX_CHANNELS);
        return r;
    endfunction

    function automatic logic [KSIZE_W-1:0] clamp_ksize(input logic [KSIZE_W-1:0] v);
        logic [KSIZE_W-1:0] r;
        r = v;
        if (v == '0)
            r = KSIZE_W'(1);
        else if (v > KSIZE_W'(MAX_KERNEL))
            r = KSIZE_W'(MAX_KERNEL);
        return r;
    endfunction

    function automatic logic [STRIDE_W-1:0] clamp_stride(input logic [STRIDE_W-1:0] v);
        logic [STRIDE_W-1:0] r;
        r = v;
        if (v == '0)
            r = STRIDE_W'(1);
        else if (v > STRIDE_W'(MAX_STRIDE))
            r = STRIDE_W'(MAX_STRIDE);
        return r;
    endfunction

endpackage

FILE: design/image_to_patch_matrix.sv
// im2col patch-matrix generator. Load requests (tuser 0) store one 32-bit word each into a
// 16384-word single-port image memory in channel, row, column order; fetch requests
// (tuser 1) return one patch element each; clear (tuser 2) rewinds the load pointer and the
// element walk. The memory is not cleared at reset. Requests are taken one per cycle while
// results are drained; a fetch result passes through two address stages, the memory's
// registered read and the result queue. Input stalls when the 8-entry result queue plus
// fetches still in the three pipeline stages reach 8. Configuration writes are taken every
// cycle and must only be made while the block is idle.
module image_to_patch_matrix (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] pixel_word
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] element_word
    output logic        m_tlast,
    output logic        m_tuser,   // [0] no_element
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    im2col_pkg::geom_t   geom_reg;
    im2col_pkg::req_t    req;
    im2col_pkg::result_t q_in, q_head;

    logic take;
    logic [im2col_pkg::OUTQ_CNT_W-1:0] q_count;
    logic [1:0] inflight;
    logic q_not_empty;

    logic                              s1_valid_reg, s1_load_reg, s1_noel_reg, s1_last_reg;
    logic [im2col_pkg::ROW_W-1:0]      s1_row_reg;
    logic [im2col_pkg::COL_W-1:0]      s1_col_reg;
    logic [im2col_pkg::WORD_BITS-1:0]  s1_word_reg;
    logic [im2col_pkg::ADDR_W-1:0]     s1_ldaddr_reg;

    logic                              s2_valid_reg, s2_load_reg, s2_noel_reg, s2_last_reg;
    logic [im2col_pkg::ADDR_W-1:0]     s2_addr_reg;
    logic [im2col_pkg::WORD_BITS-1:0]  s2_word_reg;

    logic                              s3_valid_reg, s3_noel_reg, s3_last_reg;

    logic [im2col_pkg::PROD_W-1:0]     s2_prod;
    logic [im2col_pkg::ADDR_W-1:0]     s2_addr_next;
    logic [im2col_pkg::WORD_BITS-1:0]  ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.size       <= im2col_pkg::SIZE_W'(32);
            geom_reg.chans      <= im2col_pkg::CHAN_W'(1);
            geom_reg.ksize      <= im2col_pkg::KSIZE_W'(3);
            geom_reg.stride     <= im2col_pkg::STRIDE_W'(1);
            geom_reg.row_layout <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                im2col_pkg::REG_IMAGE_SIZE:
                    geom_reg.size <= im2col_pkg::clamp_size(cfg_data[im2col_pkg::SIZE_W-1:0]);
                im2col_pkg::REG_CHANNEL_COUNT:
                    geom_reg.chans <= im2col_pkg::clamp_chans(cfg_data[im2col_pkg::CHAN_W-1:0]);
                im2col_pkg::REG_KERNEL_SIZE:
                    geom_reg.ksize <= im2col_pkg::clamp_ksize(cfg_data[im2col_pkg::KSIZE_W-1:0]);
                im2col_pkg::REG_KERNEL_STRIDE:
                    geom_reg.stride <=
                        im2col_pkg::clamp_stride(cfg_data[im2col_pkg::STRIDE_W-1:0]);
                im2col_pkg::REG_LAYOUT_MODE:
                    geom_reg.row_layout <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign inflight = 2'((s1_valid_reg & ~s1_load_reg))
                    + 2'((s2_valid_reg & ~s2_load_reg))
                    + 2'(s3_valid_reg);
    assign s_tready = ({1'b0, q_count} + (im2col_pkg::OUTQ_CNT_W + 1)'(inflight))
                      < (im2col_pkg::OUTQ_CNT_W + 1)'(im2col_pkg::OUTQ_DEPTH);
    assign take = s_tvalid & s_tready;

    im2col_walk u_walk (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .opcode (s_tuser),
        .geom   (geom_reg),
        .req    (req)
    );

    // stage 1: channel row base
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take & (req.load | req.fetch);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_load_reg   <= req.load;
        s1_noel_reg   <= req.no_elem;
        s1_last_reg   <= req.last;
        s1_row_reg    <= im2col_pkg::ROW_W'(req.ch * geom_reg.size)
                       + im2col_pkg::ROW_W'(req.pr) + im2col_pkg::ROW_W'(req.wr);
        s1_col_reg    <= im2col_pkg::COL_W'(req.pc) + im2col_pkg::COL_W'(req.wc);
        s1_word_reg   <= s_tdata;
        s1_ldaddr_reg <= req.ld_addr;
    end

    // stage 2: word address
    assign s2_prod = im2col_pkg::PROD_W'(s1_row_reg) * im2col_pkg::PROD_W'(geom_reg.size);
    assign s2_addr_next = s1_load_reg ? s1_ldaddr_reg
                        : s2_prod[im2col_pkg::ADDR_W-1:0]
                          + im2col_pkg::ADDR_W'(s1_col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_load_reg <= s1_load_reg;
        s2_noel_reg <= s1_noel_reg;
        s2_last_reg <= s1_last_reg;
        s2_addr_reg <= s2_addr_next;
        s2_word_reg <= s1_word_reg;
    end

    // loads and fetches reach the memory in request order
    im2col_ram #(
        .WIDTH (im2col_pkg::WORD_BITS),
        .DEPTH (im2col_pkg::STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (s2_valid_reg & s2_load_reg),
        .addr  (s2_addr_reg),
        .wdata (s2_word_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg & ~s2_load_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_noel_reg <= s2_noel_reg;
        s3_last_reg <= s2_last_reg;
    end

    always_comb
    begin
        q_in.word    = s3_noel_reg ? '0 : ram_rdata;
        q_in.last    = s3_last_reg;
        q_in.no_elem = s3_noel_reg;
    end

    im2col_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_valid_reg),
        .push_data (q_in),
        .pop       (m_tready),
        .head      (q_head),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    assign m_tvalid = q_not_empty;
    assign m_tdata  = q_head.word;
    assign m_tlast  = q_head.last;
    assign m_tuser  = q_head.no_elem;

endmodule

FILE: design/im2col_ram.sv
module im2col_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

FILE: design/im2col_walk.sv
module im2col_walk (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 take,
    input  logic [im2col_pkg::OPCODE_W-1:0]      opcode,
    input  im2col_pkg::geom_t                    geom,
    output im2col_pkg::req_t                     req
);

    logic [im2col_pkg::ADDR_W-1:0] lp_reg, lp_next;
    logic [im2col_pkg::CH_W-1:0]   ch_reg, ch_next;
    logic [im2col_pkg::KW_W-1:0]   wr_reg, wr_next;
    logic [im2col_pkg::KW_W-1:0]   wc_reg, wc_next;
    logic [im2col_pkg::POS_W-1:0]  pr_reg, pr_next;
    logic [im2col_pkg::POS_W-1:0]  pc_reg, pc_next;
    logic                          done_reg, done_next;

    logic [im2col_pkg::SIZE_W-1:0] top, pc_sum, pr_sum;
    logic geom_bad, out_range;
    logic w_pc, w_pr, w_wc, w_wr, w_ch;
    logic inc_pc, inc_pr, inc_wc, inc_wr, inc_ch, wrapped;

    always_comb
    begin
        top      = geom.size - im2col_pkg::SIZE_W'(geom.ksize);
        geom_bad = im2col_pkg::SIZE_W'(geom.ksize) > geom.size;
        out_range = (im2col_pkg::CHAN_W'(ch_reg) >= geom.chans)
                 || (im2col_pkg::KSIZE_W'(wr_reg) >= geom.ksize)
                 || (im2col_pkg::KSIZE_W'(wc_reg) >= geom.ksize)
                 || (im2col_pkg::SIZE_W'(pr_reg) > top)
                 || (im2col_pkg::SIZE_W'(pc_reg) > top);

        pc_sum = im2col_pkg::SIZE_W'(pc_reg) + im2col_pkg::SIZE_W'(geom.stride);
        pr_sum = im2col_pkg::SIZE_W'(pr_reg) + im2col_pkg::SIZE_W'(geom.stride);
        w_pc = pc_sum > top;
        w_pr = pr_sum > top;
        w_wc = im2col_pkg::KSIZE_W'(wc_reg) == geom.ksize - im2col_pkg::KSIZE_W'(1);
        w_wr = im2col_pkg::KSIZE_W'(wr_reg) == geom.ksize - im2col_pkg::KSIZE_W'(1);
        w_ch = im2col_pkg::CHAN_W'(ch_reg) == geom.chans - im2col_pkg::CHAN_W'(1);

        if (geom.row_layout)
        begin
            inc_wc  = 1'b1;
            inc_wr  = w_wc;
            inc_ch  = w_wc & w_wr;
            inc_pc  = w_wc & w_wr & w_ch;
            inc_pr  = w_wc & w_wr & w_ch & w_pc;
            wrapped = w_wc & w_wr & w_ch & w_pc & w_pr;
        end
        else
        begin
            inc_pc  = 1'b1;
            inc_pr  = w_pc;
            inc_wc  = w_pc & w_pr;
            inc_wr  = w_pc & w_pr & w_wc;
            inc_ch  = w_pc & w_pr & w_wc & w_wr;
            wrapped = w_pc & w_pr & w_wc & w_wr & w_ch;
        end

        lp_next   = lp_reg;
        ch_next   = ch_reg;
        wr_next   = wr_reg;
        wc_next   = wc_reg;
        pr_next   = pr_reg;
        pc_next   = pc_reg;
        done_next = done_reg;

        if (take)
        begin
            case (opcode)
                im2col_pkg::OP_LOAD:
                begin
                    lp_next = lp_reg + im2col_pkg::ADDR_W'(1);
                end
                im2col_pkg::OP_CLEAR:
                begin
                    lp_next   = '0;
                    ch_next   = '0;
                    wr_next   = '0;
                    wc_next   = '0;
                    pr_next   = '0;
                    pc_next   = '0;
                    done_next = 1'b0;
                end
                im2col_pkg::OP_FETCH:
                begin
                    if (!done_reg && !geom_bad)
                    begin
                        if (out_range)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            if (inc_pc)
                                pc_next = w_pc ? '0 : pc_sum[im2col_pkg::POS_W-1:0];
                            if (inc_pr)
                                pr_next = w_pr ? '0 : pr_sum[im2col_pkg::POS_W-1:0];
                            if (inc_wc)
                                wc_next = w_wc ? '0 : wc_reg + im2col_pkg::KW_W'(1);
                            if (inc_wr)
                                wr_next = w_wr ? '0 : wr_reg + im2col_pkg::KW_W'(1);
                            if (inc_ch)
                                ch_next = w_ch ? '0 : ch_reg + im2col_pkg::CH_W'(1);
                            if (wrapped)
                                done_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        req.load    = opcode == im2col_pkg::OP_LOAD;
        req.fetch   = opcode == im2col_pkg::OP_FETCH;
        req.no_elem = done_reg | geom_bad | out_range;
        req.last    = wrapped & ~(done_reg | geom_bad | out_range);
        req.ld_addr = lp_reg;
        req.ch      = ch_reg;
        req.wr      = wr_reg;
        req.wc      = wc_reg;
        req.pr      = pr_reg;
        req.pc      = pc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg   <= '0;
            ch_reg   <= '0;
            wr_reg   <= '0;
            wc_reg   <= '0;
            pr_reg   <= '0;
            pc_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            lp_reg   <= lp_next;
            ch_reg   <= ch_next;
            wr_reg   <= wr_next;
            wc_reg   <= wc_next;
            pr_reg   <= pr_next;
            pc_reg   <= pc_next;
            done_reg <= done_next;
        end
    end

endmodule

FILE: design/im2col_outq.sv
module im2col_outq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  im2col_pkg::result_t                 push_data,
    input  logic                                pop,
    output im2col_pkg::result_t                 head,
    output logic                                not_empty,
    output logic [im2col_pkg::OUTQ_CNT_W-1:0]   count
);

    im2col_pkg::result_t entry_reg [im2col_pkg::OUTQ_DEPTH];

    logic [im2col_pkg::OUTQ_PTR_W-1:0] wptr_reg, wptr_next;
    logic [im2col_pkg::OUTQ_PTR_W-1:0] rptr_reg, rptr_next;
    logic [im2col_pkg::OUTQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic do_pop;

    always_comb
    begin
        do_pop    = pop & (cnt_reg != '0);
        wptr_next = push ? wptr_reg + im2col_pkg::OUTQ_PTR_W'(1) : wptr_reg;
        rptr_next = do_pop ? rptr_reg + im2col_pkg::OUTQ_PTR_W'(1) : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !do_pop)
            cnt_next = cnt_reg + im2col_pkg::OUTQ_CNT_W'(1);
        else if (!push && do_pop)
            cnt_next = cnt_reg - im2col_pkg::OUTQ_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign head      = entry_reg[rptr_reg];
    assign not_empty = cnt_reg != '0;
    assign count     = cnt_reg;

endmodule

FILE: design/im2col_chk.sv
module im2col_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    logic [4:0] pending_reg;
    logic       fetch_in, result_out;

    assign fetch_in   = s_tvalid & s_tready & (s_tuser == im2col_pkg::OP_FETCH);
    assign result_out = m_tvalid & m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 5'(fetch_in) - 5'(result_out);
        end
    end

    a_result_needs_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != '0)
        else $error("result without an outstanding fetch request");

    a_pending_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 5'(im2col_pkg::OUTQ_DEPTH))
        else $error("more fetch requests outstanding than result slots");

    a_no_element_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0 && !m_tlast))
        else $error("no-element result carries data or last");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind image_to_patch_matrix im2col_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import im2col_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;

    localparam logic [OPCODE_W-1:0] OP_IGNORED = 2'd3;

    // walk counter slots
    localparam int CH = 0;
    localparam int WR = 1;
    localparam int WC = 2;
    localparam int PR = 3;
    localparam int PC = 4;

    typedef struct {
        logic [WORD_BITS-1:0] word;
        logic                 last;
        logic                 none;
    } element_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] pixel_word
    logic [1:0]  s_tuser;   // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] element_word
    logic        m_tlast;
    logic        m_tuser;   // [0] no_element
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    image_to_patch_matrix dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the block
    logic [WORD_BITS-1:0] image_shadow [STORE_DEPTH];
    bit                   shadow_written [STORE_DEPTH];
    int unsigned          load_ptr;
    int unsigned          walk [5];
    bit                   walk_done;
    logic [7:0]           reg_value [5] = '{8'd32, 8'd1, 8'd3, 8'd1, 8'd0};

    element_t    pending_elements [$];
    int unsigned mismatch_count = 0;
    int unsigned src_gap_pct    = 23;
    int unsigned sink_stall_pct = 55;
    int unsigned sink_hold      = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [7:0] field_mask(input logic [CFG_IDX_W-1:0] idx);
        case (idx)
            REG_IMAGE_SIZE:    return 8'h3F;
            REG_CHANNEL_COUNT: return 8'h1F;
            REG_KERNEL_SIZE:   return 8'h0F;
            REG_KERNEL_STRIDE: return 8'h0F;
            REG_LAYOUT_MODE:   return 8'h01;
            default:           return 8'h00;
        endcase
    endfunction

    function automatic void read_geometry(output int unsigned s, output int unsigned c,
                                          output int unsigned k, output int unsigned t);
        s = clamp_to(reg_value[REG_IMAGE_SIZE], MAX_IMAGE);
        c = clamp_to(reg_value[REG_CHANNEL_COUNT], MAX_CHANNELS);
        k = clamp_to(reg_value[REG_KERNEL_SIZE], MAX_KERNEL);
        t = clamp_to(reg_value[REG_KERNEL_STRIDE], MAX_STRIDE);
    endfunction

    // 1 when the next fetch reads the store; addr is the entry it reads
    function automatic bit fetch_reads(output int unsigned addr);
        int unsigned s, c, k, t, top;
        read_geometry(s, c, k, t);
        addr = 0;
        if (walk_done || k > s)
            return 0;
        top = s - k;
        if (walk[CH] >= c || walk[WR] >= k || walk[WC] >= k || walk[PR] > top || walk[PC] > top)
            return 0;
        addr = ((walk[CH] * s + walk[PR] + walk[WR]) * s + walk[PC] + walk[WC]) % STORE_DEPTH;
        return 1;
    endfunction

    function automatic void rewind_walk();
        load_ptr = 0;
        foreach (walk[i])
            walk[i] = 0;
        walk_done = 0;
    endfunction

    function automatic void track_request(input logic [OPCODE_W-1:0] op,
                                          input logic [WORD_BITS-1:0] word);
        element_t    e;
        int unsigned addr, s, c, k, t, top, slot, step, lim;
        int unsigned order [5];
        bit          carry;
        read_geometry(s, c, k, t);
        case (op)
            OP_LOAD:
            begin
                image_shadow[load_ptr]   = word;
                shadow_written[load_ptr] = 1;
                load_ptr = (load_ptr + 1) % STORE_DEPTH;
            end
            OP_CLEAR:
                rewind_walk();
            OP_FETCH:
            begin
                e.word = '0;
                e.last = 1'b0;
                e.none = 1'b1;
                if (fetch_reads(addr))
                begin
                    e.word = image_shadow[addr];
                    e.none = 1'b0;
                    top = s - k;
                    if (reg_value[REG_LAYOUT_MODE][0] == 1'b0)
                        order = '{PC, PR, WC, WR, CH};
                    else
                        order = '{WC, WR, CH, PC, PR};
                    carry = 1;
                    foreach (order[i])
                    begin
                        if (carry)
                        begin
                            slot = order[i];
                            step = (slot == PR || slot == PC) ? t : 1;
                            lim  = (slot == CH) ? c - 1 :
                                   (slot == PR || slot == PC) ? top : k - 1;
                            if (walk[slot] + step <= lim)
                            begin
                                walk[slot] = walk[slot] + step;
                                carry = 0;
                            end
                            else
                                walk[slot] = 0;
                        end
                    end
                    if (carry)
                    begin
                        e.last    = 1'b1;
                        walk_done = 1;
                    end
                end
                else if (k <= s)
                    walk_done = 1;   // walk left the geometry, or already done
                pending_elements.push_back(e);
            end
            default: ;
        endcase
    endfunction

    // entered and left just after a falling edge
    task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [WORD_BITS-1:0] word);
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        track_request(op, word);
        @(negedge clk);
    endtask

    // never reads an entry that no load has written
    task automatic send_fetch();
        int unsigned addr;
        if (fetch_reads(addr) && !shadow_written[addr])
            send_request(OP_LOAD, $urandom());
        else
            send_request(OP_FETCH, $urandom());
    endtask

    task automatic send_noise();
        if ($urandom_range(29) == 0)
            send_request(OP_IGNORED, $urandom());
    endtask

    task automatic await_idle();
        s_tvalid <= 1'b0;
        while (pending_elements.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        await_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        reg_value[idx] = data & field_mask(idx);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random unused upper bits; 1 sometimes as 0, the maximum sometimes above it
    function automatic logic [7:0] encode_reg(input int unsigned v, input int unsigned w,
                                              input int unsigned hi);
        logic [7:0]  raw;
        int unsigned f;
        f = v;
        if (v == 1 && $urandom_range(1) == 1)
            f = 0;
        else if (v == hi && $urandom_range(1) == 1)
            f = $urandom_range((1 << w) - 1, hi + 1);
        raw = $urandom();
        raw = (raw & ~8'((1 << w) - 1)) | 8'(f);
        return raw;
    endfunction

    task automatic set_geometry(input int unsigned s, input int unsigned c, input int unsigned k,
                                input int unsigned t, input bit row_layout);
        write_register(REG_IMAGE_SIZE, encode_reg(s, SIZE_W, MAX_IMAGE));
        write_register(REG_CHANNEL_COUNT, encode_reg(c, CHAN_W, MAX_CHANNELS));
        write_register(REG_KERNEL_SIZE, encode_reg(k, KSIZE_W, MAX_KERNEL));
        write_register(REG_KERNEL_STRIDE, encode_reg(t, STRIDE_W, MAX_STRIDE));
        write_register(REG_LAYOUT_MODE, {7'($urandom()), row_layout});
    endtask

    task automatic test_reset_geometry();
        send_request(OP_LOAD, 32'h0000_0000);
        send_request(OP_LOAD, 32'hFFFF_FFFF);
        send_request(OP_LOAD, 32'hAAAA_AAAA);
        send_request(OP_LOAD, 32'h5555_5555);
        send_request(OP_IGNORED, 32'hFFFF_FFFF);
        repeat (3) send_fetch();
    endtask

    task automatic test_register_limits();
        // zero reads as one, upper bits dropped
        write_register(REG_IMAGE_SIZE, 8'h00);
        write_register(REG_CHANNEL_COUNT, 8'hE0);
        write_register(REG_KERNEL_SIZE, 8'hF0);
        write_register(REG_KERNEL_STRIDE, 8'h00);
        write_register(REG_LAYOUT_MODE, 8'hFE);
        send_request(OP_CLEAR, 32'hFFFF_FFFF);
        send_request(OP_LOAD, 32'h8000_0001);
        send_fetch();
        send_fetch();
        // kernel larger than image
        write_register(REG_IMAGE_SIZE, 8'h02);
        write_register(REG_KERNEL_SIZE, 8'h03);
        send_request(OP_CLEAR, 32'h0);
        send_fetch();
        // above range reads as the maximum
        write_register(REG_IMAGE_SIZE, 8'hFF);
        write_register(REG_CHANNEL_COUNT, 8'hFF);
        write_register(REG_KERNEL_SIZE, 8'hFF);
        write_register(REG_KERNEL_STRIDE, 8'hFF);
        write_register(REG_LAYOUT_MODE, 8'hFF);
        send_request(OP_CLEAR, 32'h0);
        repeat (4) send_request(OP_LOAD, $urandom());
        repeat (4) send_fetch();
    endtask

    task automatic test_geometry_change();
        write_register(REG_IMAGE_SIZE, 8'd3);
        write_register(REG_CHANNEL_COUNT, 8'd1);
        write_register(REG_KERNEL_SIZE, 8'd1);
        write_register(REG_KERNEL_STRIDE, 8'd2);
        write_register(REG_LAYOUT_MODE, 8'd0);
        send_request(OP_CLEAR, 32'h0);
        repeat (3) send_request(OP_LOAD, $urandom());
        repeat (2) send_fetch();
        // position row now beyond the smaller image
        write_register(REG_IMAGE_SIZE, 8'd2);
        repeat (2) send_fetch();
    endtask

    task automatic test_random_traffic(input int unsigned n_items, input int unsigned gap_pct,
                                       input int unsigned stall_pct);
        int unsigned counted, s, c, k, t, p, elems, fetches;
        src_gap_pct    = gap_pct;
        sink_stall_pct = stall_pct;
        counted = 0;
        while (counted < n_items)
        begin
            do
            begin
                s = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
                c = ($urandom_range(9) == 0) ? $urandom_range(MAX_CHANNELS, 4)
                                              : $urandom_range(3, 1);
                k = $urandom_range((s < MAX_KERNEL) ? s + 1 : MAX_KERNEL, 1);
                t = ($urandom_range(3) == 0) ? $urandom_range(MAX_STRIDE, 4)
                                              : $urandom_range(3, 1);
                elems = 0;
                if (k <= s)
                begin
                    p = (s - k) / t + 1;
                    elems = c * k * k * p * p;
                end
            end
            while (elems > 96 || c * s * s > 150);
            set_geometry(s, c, k, t, $urandom_range(1));
            send_request(OP_CLEAR, $urandom());
            counted++;
            for (int i = 0; i < c * s * s; i++)
            begin
                if ($urandom_range(49) == 0)
                    break;   // short image
                send_noise();
                send_request(OP_LOAD, $urandom());
                counted++;
            end
            fetches = elems + $urandom_range(2, 1);
            for (int i = 0; i < fetches; i++)
            begin
                if ($urandom_range(99) == 0)
                begin
                    send_request(OP_CLEAR, $urandom());
                    counted++;
                end
                send_noise();
                send_fetch();
                counted++;
            end
        end
    endtask

    task automatic test_output_backpressure();
        src_gap_pct = 0;
        set_geometry(4, 1, 2, 1, 0);
        send_request(OP_CLEAR, $urandom());
        repeat (16) send_request(OP_LOAD, $urandom());
        sink_hold = HOLD_CYCLES;
        repeat (37) send_fetch();
    endtask

    initial
    begin : result_sink
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                sink_hold--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        element_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_elements.size() == 0)
            begin
                $error("unexpected result: element_word %h", m_tdata);
                mismatch_count++;
            end
            else
            begin
                e = pending_elements.pop_front();
                if (m_tdata !== e.word)
                begin
                    $error("element_word: expected %h, actual %h", e.word, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last_element: expected %b, actual %b", e.last, m_tlast);
                    mismatch_count++;
                end
                if (m_tuser !== e.none)
                begin
                    $error("no_element: expected %b, actual %b", e.none, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_LOAD;
        cfg_valid = 1'b0;
        cfg_index = REG_IMAGE_SIZE;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_geometry();
        test_register_limits();
        test_geometry_change();
        test_random_traffic(190, 23, 55);
        test_random_traffic(190, 55, 23);
        test_random_traffic(190, 0, 0);
        test_output_backpressure();
        await_idle();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
